FILE: design/jacobi_heat_grid_solver_top_macros.svh
// Assertion macros for the Jacobi heat grid solver.
// Expects signals named clk and rst in the including scope.
`ifndef JACOBI_HEAT_GRID_SOLVER_TOP_MACROS_SVH
`define JACOBI_HEAT_GRID_SOLVER_TOP_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define JHGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define JHGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/jhgs_pkg.sv
// Shared constants, codes and types of the Jacobi heat grid solver.
// No dependencies.
`default_nettype none
package jhgs_pkg;

  localparam int ROWS      = 32;
  localparam int COLS      = 32;
  localparam int FRAC_BITS = 16;

  localparam int CELLS    = ROWS * COLS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int COL_W    = $clog2(COLS);
  localparam int LINE_LEN = 2 * COLS + 1;

  localparam int REG_W     = 8;
  localparam int VAL_W     = REG_W + FRAC_BITS;
  localparam int OP_W      = 2;
  localparam int ROW_IN_W  = 5;
  localparam int COUNT_W   = 16;
  localparam int COL_OUT_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 2'd0,
    OP_ITERATE = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd3;

  localparam logic [REG_W-1:0] LEFT_RESET   = 8'd75;
  localparam logic [REG_W-1:0] RIGHT_RESET  = 8'd25;
  localparam logic [REG_W-1:0] TOP_RESET    = 8'd100;
  localparam logic [REG_W-1:0] BOTTOM_RESET = 8'd50;

  // tag of a sweep read whose data arrives from the grid memory
  typedef struct packed {
    logic              valid;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ADDR_W-1:0] addr;
  } tag_t;

  // write request from the stencil into the destination grid
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } wr_t;

  function automatic logic [VAL_W-1:0] to_fixed(input logic [REG_W-1:0] v);
    return {v, {FRAC_BITS{1'b0}}};
  endfunction

endpackage
`default_nettype wire

FILE: design/jhgs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module jhgs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/jhgs_stencil.sv
// Five-point stencil: line buffer of two rows plus one over the raster
// stream of the source grid, neighbor sum and write request. Uses jhgs_pkg.
`default_nettype none
module jhgs_stencil (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire jhgs_pkg::tag_t             tag,
  input  wire logic [jhgs_pkg::VAL_W-1:0] rd_data,
  output jhgs_pkg::wr_t                   wr,
  output logic                            busy
);

  // line[i] holds the cell at line_tag.addr - i
  logic [jhgs_pkg::VAL_W-1:0] line [jhgs_pkg::LINE_LEN];
  jhgs_pkg::tag_t             line_tag;
  logic [jhgs_pkg::VAL_W+1:0] sum;
  logic                       interior;

  always_ff @(posedge clk) begin
    if (tag.valid) begin
      line[0] <= rd_data;
      for (int i = 1; i < jhgs_pkg::LINE_LEN; i++) begin
        line[i] <= line[i-1];
      end
    end
    if (rst) begin
      line_tag.valid <= 1'b0;
    end else begin
      line_tag.valid <= tag.valid;
    end
    line_tag.row  <= tag.row;
    line_tag.col  <= tag.col;
    line_tag.addr <= tag.addr;
  end

  // center is one row above the newest cell
  always_comb begin
    interior = (line_tag.row >= jhgs_pkg::ROW_W'(2))
            && (line_tag.col >= jhgs_pkg::COL_W'(1))
            && (line_tag.col <= jhgs_pkg::COL_W'(jhgs_pkg::COLS - 2));
    sum = (jhgs_pkg::VAL_W+2)'(line[0])
        + (jhgs_pkg::VAL_W+2)'(line[jhgs_pkg::COLS-1])
        + (jhgs_pkg::VAL_W+2)'(line[jhgs_pkg::COLS+1])
        + (jhgs_pkg::VAL_W+2)'(line[2*jhgs_pkg::COLS]);
    wr.en   = line_tag.valid && interior;
    wr.addr = line_tag.addr - jhgs_pkg::ADDR_W'(jhgs_pkg::COLS);
    wr.data = sum[jhgs_pkg::VAL_W+1:2];
  end

  assign busy = line_tag.valid;

endmodule
`default_nettype wire

FILE: design/jacobi_heat_grid_solver_top.sv
// Init: writes every cell of both grid memories. Iterate: count sweeps, one cell
// read per cycle from the current grid memory, each followed by a drain of the stencil.
// Read row: each cell passes the registered memory read and the single output register;
// the next cell is not read while the output holds a stalled transaction.
// Reset clears control and current select and loads the register defaults;
// grid memories are undefined until an init command, no clearing pass.
`default_nettype none
module jacobi_heat_grid_solver_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // row_index [4:0], sweep_count [20:5], zero pad
  input  wire logic [jhgs_pkg::S_DATA_W-1:0]    s_tdata,
  // op [1:0]
  input  wire logic [jhgs_pkg::OP_W-1:0]        s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // column [4:0], cell_value [28:5], zero pad
  output logic      [jhgs_pkg::M_DATA_W-1:0]    m_tdata,
  output logic                                  m_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [jhgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [jhgs_pkg::REG_W-1:0]       cfg_data
);

  `include "jacobi_heat_grid_solver_top_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_SWEEP, S_DRAIN, S_RD_ISSUE, S_RD_WAIT
  } state_t;

  localparam int PAD_W = jhgs_pkg::M_DATA_W - jhgs_pkg::VAL_W - jhgs_pkg::COL_OUT_W;

  state_t                             state;
  logic                               cur;
  logic [jhgs_pkg::COUNT_W-1:0]       remaining;
  logic [jhgs_pkg::ADDR_W-1:0]        cnt_addr, cnt_addr_next;
  logic [jhgs_pkg::ROW_W-1:0]         cnt_row, cnt_row_next;
  logic [jhgs_pkg::COL_W-1:0]         cnt_col, cnt_col_next;
  logic                               cnt_end;
  logic [jhgs_pkg::REG_W-1:0]         bnd_left, bnd_right, bnd_top, bnd_bottom;
  logic [jhgs_pkg::COL_OUT_W-1:0]     out_col;
  logic [jhgs_pkg::VAL_W-1:0]         out_val;
  jhgs_pkg::tag_t                     rd_tag;
  jhgs_pkg::wr_t                      wr;
  logic                               busy;
  logic                               out_load;

  logic [jhgs_pkg::ROW_IN_W-1:0]      in_row;
  logic [jhgs_pkg::COUNT_W-1:0]       in_count;
  jhgs_pkg::op_t                      in_op;

  logic [jhgs_pkg::VAL_W-1:0]         rdata_a, rdata_b, rd_data, init_value;
  logic                               we_a, we_b;
  logic [jhgs_pkg::ADDR_W-1:0]        waddr;
  logic [jhgs_pkg::VAL_W-1:0]         wdata;

  assign in_row   = s_tdata[jhgs_pkg::ROW_IN_W-1:0];
  assign in_count = s_tdata[jhgs_pkg::ROW_IN_W+jhgs_pkg::COUNT_W-1:jhgs_pkg::ROW_IN_W];
  assign in_op    = jhgs_pkg::op_t'(s_tuser);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {{PAD_W{1'b0}}, out_val, out_col};
  assign out_load = (state == S_RD_WAIT);
  assign rd_data  = cur ? rdata_b : rdata_a;

  always_comb begin
    cnt_addr_next = cnt_addr + jhgs_pkg::ADDR_W'(1);
    cnt_end       = (cnt_addr == jhgs_pkg::ADDR_W'(jhgs_pkg::CELLS - 1));
    if (cnt_col == jhgs_pkg::COL_W'(jhgs_pkg::COLS - 1)) begin
      cnt_col_next = '0;
      cnt_row_next = cnt_row + jhgs_pkg::ROW_W'(1);
    end else begin
      cnt_col_next = cnt_col + jhgs_pkg::COL_W'(1);
      cnt_row_next = cnt_row;
    end
  end

  always_comb begin
    if (cnt_col == '0) begin
      init_value = jhgs_pkg::to_fixed(bnd_left);
    end else if (cnt_col == jhgs_pkg::COL_W'(jhgs_pkg::COLS - 1)) begin
      init_value = jhgs_pkg::to_fixed(bnd_right);
    end else if (cnt_row == '0) begin
      init_value = jhgs_pkg::to_fixed(bnd_top);
    end else if (cnt_row == jhgs_pkg::ROW_W'(jhgs_pkg::ROWS - 1)) begin
      init_value = jhgs_pkg::to_fixed(bnd_bottom);
    end else begin
      init_value = '0;
    end
  end

  always_comb begin
    if (state == S_INIT) begin
      we_a  = 1'b1;
      we_b  = 1'b1;
      waddr = cnt_addr;
      wdata = init_value;
    end else begin
      we_a  = wr.en && cur;
      we_b  = wr.en && !cur;
      waddr = wr.addr;
      wdata = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_left   <= jhgs_pkg::LEFT_RESET;
      bnd_right  <= jhgs_pkg::RIGHT_RESET;
      bnd_top    <= jhgs_pkg::TOP_RESET;
      bnd_bottom <= jhgs_pkg::BOTTOM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        jhgs_pkg::REG_LEFT:   bnd_left   <= cfg_data;
        jhgs_pkg::REG_RIGHT:  bnd_right  <= cfg_data;
        jhgs_pkg::REG_TOP:    bnd_top    <= cfg_data;
        jhgs_pkg::REG_BOTTOM: bnd_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur          <= 1'b0;
      m_tvalid     <= 1'b0;
      rd_tag.valid <= 1'b0;
    end else begin
      rd_tag.valid <= (state == S_SWEEP);
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cnt_row  <= '0;
            cnt_col  <= '0;
            case (in_op)
              jhgs_pkg::OP_INIT: begin
                cnt_addr <= '0;
                state    <= S_INIT;
              end
              jhgs_pkg::OP_ITERATE: begin
                cnt_addr  <= '0;
                remaining <= in_count;
                if (in_count != '0) begin
                  state <= S_SWEEP;
                end
              end
              jhgs_pkg::OP_READ: begin
                cnt_addr <= jhgs_pkg::ADDR_W'(in_row) * jhgs_pkg::ADDR_W'(jhgs_pkg::COLS);
                if (32'(in_row) < jhgs_pkg::ROWS) begin
                  state <= S_RD_ISSUE;
                end
              end
              default: cnt_addr <= '0;
            endcase
          end
        end
        S_INIT: begin
          cnt_addr <= cnt_addr_next;
          cnt_row  <= cnt_row_next;
          cnt_col  <= cnt_col_next;
          if (cnt_end) begin
            cur   <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_SWEEP: begin
          rd_tag.row   <= cnt_row;
          rd_tag.col   <= cnt_col;
          rd_tag.addr  <= cnt_addr;
          cnt_addr     <= cnt_addr_next;
          cnt_row      <= cnt_row_next;
          cnt_col      <= cnt_col_next;
          if (cnt_end) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_tag.valid && !busy) begin
            cur       <= ~cur;
            remaining <= remaining - jhgs_pkg::COUNT_W'(1);
            cnt_addr  <= '0;
            cnt_row   <= '0;
            cnt_col   <= '0;
            if (remaining == jhgs_pkg::COUNT_W'(1)) begin
              state <= S_IDLE;
            end else begin
              state <= S_SWEEP;
            end
          end
        end
        S_RD_ISSUE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_RD_WAIT;
          end
        end
        S_RD_WAIT: begin
          m_tvalid <= 1'b1;
          out_col  <= jhgs_pkg::COL_OUT_W'(cnt_col);
          out_val  <= rd_data;
          m_tlast  <= (cnt_col == jhgs_pkg::COL_W'(jhgs_pkg::COLS - 1));
          cnt_addr <= cnt_addr_next;
          cnt_col  <= cnt_col_next;
          if (cnt_col == jhgs_pkg::COL_W'(jhgs_pkg::COLS - 1)) begin
            state <= S_IDLE;
          end else begin
            state <= S_RD_ISSUE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  jhgs_ram #(.WIDTH(jhgs_pkg::VAL_W), .DEPTH(jhgs_pkg::CELLS)) u_grid_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt_addr),
    .rdata (rdata_a)
  );

  jhgs_ram #(.WIDTH(jhgs_pkg::VAL_W), .DEPTH(jhgs_pkg::CELLS)) u_grid_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt_addr),
    .rdata (rdata_b)
  );

  jhgs_stencil u_stencil (
    .clk     (clk),
    .rst     (rst),
    .tag     (rd_tag),
    .rd_data (rd_data),
    .wr      (wr),
    .busy    (busy)
  );

  `JHGS_ASSERT_IMP(a_out_no_overwrite, out_load, !m_tvalid,
    "output register loaded while holding a stalled transaction")
  `JHGS_ASSERT_IMP(a_idle_pipe_empty, state == S_IDLE, !rd_tag.valid && !busy,
    "sweep pipeline not empty while idle")
  `JHGS_ASSERT_IMP(a_stencil_write_in_sweep, wr.en, state == S_SWEEP || state == S_DRAIN,
    "stencil write outside a sweep")

endmodule
`default_nettype wire

FILE: dv/tb_jacobi_heat_grid_solver_top.sv
// Testbench for jacobi_heat_grid_solver_top: directed and random command
// streams checked against a cycle-free Jacobi grid predictor.
// Depends on jhgs_pkg and the solver RTL.
`default_nettype none
module tb_jacobi_heat_grid_solver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jhgs_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int SLACK        = 16;
  localparam int INIT_CYCLES  = CELLS + SLACK;
  localparam int SWEEP_CYCLES = CELLS + 3;
  localparam int READ_CYCLES  = 2 * COLS + SLACK;
  localparam int SWEEP_BUDGET = 300;
  localparam int RANDOM_ITEMS = 235;

  typedef struct packed {
    logic [COL_OUT_W-1:0] column;
    logic [VAL_W-1:0]     cell_value;
    logic                 last;
  } cell_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_W-1:0]      cfg_data = '0;

  // predictor state
  logic [VAL_W-1:0] heat [2][CELLS];
  logic             cur_grid;
  logic [REG_W-1:0] bound_left, bound_right, bound_top, bound_bottom;
  cell_t            cells_due [$];
  int               busy_cycles;
  int               mismatches;
  bit               no_gaps;

  jacobi_heat_grid_solver_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void relax_once();
    logic [VAL_W+1:0] acc;
    int k;
    for (int r = 1; r < ROWS - 1; r++) begin
      for (int c = 1; c < COLS - 1; c++) begin
        k = r * COLS + c;
        acc = heat[cur_grid][k-COLS] + heat[cur_grid][k+COLS]
            + heat[cur_grid][k-1] + heat[cur_grid][k+1];
        heat[!cur_grid][k] = acc[VAL_W+1:2];
      end
    end
    cur_grid = !cur_grid;
  endfunction

  function automatic void apply_command(input logic [OP_W-1:0] op,
                                        input logic [ROW_IN_W-1:0] row,
                                        input logic [COUNT_W-1:0] count);
    logic [VAL_W-1:0] v;
    int r, c;
    case (op)
      OP_INIT: begin
        for (int k = 0; k < CELLS; k++) begin
          r = k / COLS;
          c = k % COLS;
          if (c == 0) v = {bound_left, {FRAC_BITS{1'b0}}};
          else if (c == COLS - 1) v = {bound_right, {FRAC_BITS{1'b0}}};
          else if (r == 0) v = {bound_top, {FRAC_BITS{1'b0}}};
          else if (r == ROWS - 1) v = {bound_bottom, {FRAC_BITS{1'b0}}};
          else v = '0;
          heat[0][k] = v;
          heat[1][k] = v;
        end
        cur_grid = 1'b0;
        busy_cycles += INIT_CYCLES;
      end
      OP_ITERATE: begin
        repeat (count) relax_once();
        busy_cycles += int'(count) * SWEEP_CYCLES + SLACK;
      end
      OP_READ: begin
        if (row < ROWS) begin
          for (int col = 0; col < COLS; col++)
            cells_due.push_back('{column: col[COL_OUT_W-1:0],
                                  cell_value: heat[cur_grid][int'(row) * COLS + col],
                                  last: (col == COLS - 1)});
        end
        busy_cycles += READ_CYCLES;
      end
      default: busy_cycles += SLACK;
    endcase
  endfunction

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ROW_IN_W-1:0] row,
                          input logic [COUNT_W-1:0] count);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(S_DATA_W-ROW_IN_W-COUNT_W){1'b0}}, count, row};
    do @(posedge clk); while (!s_tready);
    apply_command(op, row, count);
  endtask

  // stop sending, wait for every pending row cell, then let the block settle
  task automatic wait_idle();
    int guard;
    @(negedge clk);
    s_tvalid <= 1'b0;
    guard = 0;
    while (cells_due.size() != 0 && guard < busy_cycles + 10000) begin
      @(posedge clk);
      guard++;
    end
    if (cells_due.size() != 0) begin
      $error("%0d row cells never arrived", cells_due.size());
      mismatches++;
      cells_due.delete();
    end
    repeat (busy_cycles) @(posedge clk);
    busy_cycles = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_LEFT:   bound_left   = val;
      REG_RIGHT:  bound_right  = val;
      REG_TOP:    bound_top    = val;
      REG_BOTTOM: bound_bottom = val;
      default: ;
    endcase
  endtask

  always @(negedge clk) m_tready <= no_gaps || ($urandom_range(99) >= 30);

  always @(posedge clk) begin : check_cells
    cell_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (cells_due.size() == 0) begin
        $error("unexpected cell: column %0d value %h", m_tdata[4:0], m_tdata[28:5]);
        mismatches++;
      end else begin
        want = cells_due.pop_front();
        if (m_tdata[4:0] !== want.column) begin
          $error("column: expected %0d, got %0d", want.column, m_tdata[4:0]);
          mismatches++;
        end
        if (m_tdata[28:5] !== want.cell_value) begin
          $error("cell_value: expected %h, got %h", want.cell_value, m_tdata[28:5]);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  task automatic test_reset_boundary();
    send_cmd(OP_INIT, '0, '0);
    send_cmd(OP_READ, 5'd0, '0);
    send_cmd(OP_READ, 5'd31, '0);
    send_cmd(OP_READ, 5'd15, '0);
  endtask

  task automatic test_zero_sweeps();
    send_cmd(OP_ITERATE, 5'd4, 16'd0);
    send_cmd(OP_READ, 5'd1, '0);
  endtask

  task automatic test_single_sweeps();
    send_cmd(OP_ITERATE, '0, 16'd1);
    send_cmd(OP_READ, 5'd1, '0);
    send_cmd(OP_READ, 5'd30, '0);
    send_cmd(OP_ITERATE, '0, 16'd1);
    send_cmd(OP_READ, 5'd1, '0);
  endtask

  task automatic test_ignored_op();
    send_cmd(OP_NONE, '1, '1);
    send_cmd(OP_READ, 5'd2, '0);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_LEFT, 8'hFF);
    write_reg(REG_RIGHT, 8'hFF);
    write_reg(REG_TOP, 8'hFF);
    write_reg(REG_BOTTOM, 8'hFF);
    send_cmd(OP_INIT, '0, '0);
    send_cmd(OP_ITERATE, '0, 16'd20);
    send_cmd(OP_READ, 5'd0, '0);
    send_cmd(OP_READ, 5'd16, '0);
    wait_idle();
    write_reg(REG_LEFT, 8'h00);
    write_reg(REG_RIGHT, 8'h00);
    write_reg(REG_TOP, 8'h00);
    write_reg(REG_BOTTOM, 8'h00);
    send_cmd(OP_INIT, '0, '0);
    send_cmd(OP_ITERATE, '0, 16'd2);
    send_cmd(OP_READ, 5'd1, '0);
  endtask

  task automatic test_field_extremes();
    wait_idle();
    write_reg(REG_LEFT, 8'd200);
    write_reg(REG_TOP, 8'd1);
    send_cmd(OP_INIT, '1, '1);
    send_cmd(OP_ITERATE, '1, 16'd0);
    send_cmd(OP_READ, 5'd31, '1);
    send_cmd(OP_ITERATE, '1, 16'd3);
    send_cmd(OP_READ, 5'd16, 16'h5555);
  endtask

  task automatic test_random_traffic();
    int sent, sweeps_left, pick, phase;
    logic [REG_W-1:0] val;
    logic [COUNT_W-1:0] n;
    sent = 0;
    sweeps_left = SWEEP_BUDGET;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      no_gaps = (phase == 2);
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(1) == 1 || i == phase % 4) begin
          pick = $urandom_range(3);
          val = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : REG_W'($urandom);
          write_reg(i[CFG_IDX_W-1:0], val);
        end
      end
      send_cmd(OP_INIT, ROW_IN_W'($urandom), COUNT_W'($urandom));
      sent++;
      repeat (40) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          send_cmd(OP_READ, ROW_IN_W'($urandom), COUNT_W'($urandom));
          sent++;
        end else if (pick < 75) begin
          n = ($urandom_range(7) == 0) ? COUNT_W'($urandom_range(10, 4))
                                       : COUNT_W'($urandom_range(3, 0));
          if (int'(n) > sweeps_left) n = '0;
          sweeps_left -= int'(n);
          send_cmd(OP_ITERATE, ROW_IN_W'($urandom), n);
          sent++;
        end else if (pick < 85) begin
          send_cmd(OP_INIT, ROW_IN_W'($urandom), COUNT_W'($urandom));
          sent++;
        end else begin
          send_cmd(OP_NONE, ROW_IN_W'($urandom), COUNT_W'($urandom));
          sent++;
        end
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    cur_grid     = 1'b0;
    bound_left   = LEFT_RESET;
    bound_right  = RIGHT_RESET;
    bound_top    = TOP_RESET;
    bound_bottom = BOTTOM_RESET;
    busy_cycles  = 0;
    mismatches   = 0;
    no_gaps      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_boundary();
    test_zero_sweeps();
    test_single_sweeps();
    test_ignored_op();
    test_register_extremes();
    test_field_extremes();
    test_random_traffic();
    wait_idle();

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
